>>> src/cld_pkg.sv
// ----------------------------------------------------------------------------
// cld_pkg
// shared types and constants for the core load dispatcher
// ----------------------------------------------------------------------------
package cld_pkg;

    localparam int LOAD_W      = 13;
    localparam int ACT_W       = 5;
    localparam int CORE_FLD_W  = 4;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 13;

    // command kinds
    localparam logic KIND_ASSIGN  = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ASSIGNED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CORES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CORE_CAPACITY = 1'd1;

    typedef struct packed {
        logic                  kind;
        logic [LOAD_W-1:0]     job_load;
        logic [CORE_FLD_W-1:0] release_core;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [CORE_FLD_W-1:0] chosen_core;
    } result_t;

    typedef struct packed {
        logic [ACT_W-1:0]  active_cores;
        logic [LOAD_W-1:0] core_capacity;
    } cfg_t;

endpackage

>>> src/cld_load_ram.sv
// ----------------------------------------------------------------------------
// cld_load_ram
// per-core load memory, one write and one registered read port, valid bits
// ----------------------------------------------------------------------------
module cld_load_ram #(
    parameter int NUM_CORES = 16,
    parameter int IDX_W     = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [IDX_W-1:0]          rd_addr,
    output logic [cld_pkg::LOAD_W-1:0] rd_data,
    input  logic                      wr_en,
    input  logic [IDX_W-1:0]          wr_addr,
    input  logic [cld_pkg::LOAD_W-1:0] wr_data
);
    import cld_pkg::*;

    logic [LOAD_W-1:0]    mem [NUM_CORES];
    logic [NUM_CORES-1:0] vld_reg;
    logic [LOAD_W-1:0]    rd_mem_reg;
    logic                 rd_vld_reg;

    // entries never written read as zero load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_mem_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_mem_reg : '0;

endmodule

>>> src/cld_sequencer.sv
// ----------------------------------------------------------------------------
// cld_sequencer
// scan sequencer with one shared fit/least compare unit and load update
// ----------------------------------------------------------------------------
module cld_sequencer #(
    parameter int NUM_CORES = 16,
    parameter int IDX_W     = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cld_pkg::cfg_t              cfg,
    input  logic                       start,
    input  cld_pkg::cmd_t              cmd,
    output logic                       busy,
    output logic                       done,
    output cld_pkg::result_t           result,
    output logic                       rd_en,
    output logic [IDX_W-1:0]           rd_addr,
    input  logic [cld_pkg::LOAD_W-1:0] rd_data,
    output logic                       wr_en,
    output logic [IDX_W-1:0]           wr_addr,
    output logic [cld_pkg::LOAD_W-1:0] wr_data
);
    import cld_pkg::*;

    localparam int CW = IDX_W + ACT_W;
    localparam int RW = IDX_W + CORE_FLD_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_COMMIT = 3'd3;
    localparam logic [2:0] S_REL_RD = 3'd4;
    localparam logic [2:0] S_REL_WR = 3'd5;

    logic [2:0]            state_reg,     state_next;
    logic [IDX_W-1:0]      scan_idx_reg,  scan_idx_next;
    logic [IDX_W-1:0]      last_idx_reg,  last_idx_next;
    logic                  cmp_vld_reg,   cmp_vld_next;
    logic [IDX_W-1:0]      cmp_idx_reg,   cmp_idx_next;
    logic                  fit_reg,       fit_next;
    logic                  have_idle_reg, have_idle_next;
    logic                  done_reg,      done_next;
    logic [IDX_W-1:0]      idle_idx_reg,  idle_idx_next;
    logic [LOAD_W-1:0]     least_reg,     least_next;
    logic [IDX_W-1:0]      least_idx_reg, least_idx_next;
    logic [LOAD_W-1:0]     task_reg,      task_next;
    logic [CORE_FLD_W-1:0] rel_reg,       rel_next;
    result_t               result_reg,    result_next;

    logic [CW-1:0]     act_wide;
    logic [CW-1:0]     act_count;
    logic [CW-1:0]     act_last;
    logic [RW-1:0]     rel_wide;
    logic              rel_in_range;
    logic [LOAD_W:0]   fit_sum;
    logic              fit_now;
    logic [IDX_W-1:0]  pick_idx;
    logic [RW-1:0]     pick_wide;
    logic [LOAD_W-1:0] rel_sub;

    function automatic logic [IDX_W-1:0] rel_wide_idx(input logic [CORE_FLD_W-1:0] r);
        logic [RW-1:0] w;
        w = {{IDX_W{1'b0}}, r};
        return w[IDX_W-1:0];
    endfunction

    // searched core count clamped to 1..NUM_CORES
    always_comb
    begin
        act_wide = {{IDX_W{1'b0}}, cfg.active_cores};
        if (act_wide == '0)
        begin
            act_count = CW'(1);
        end
        else if (act_wide > CW'(NUM_CORES))
        begin
            act_count = CW'(NUM_CORES);
        end
        else
        begin
            act_count = act_wide;
        end
        act_last = act_count - CW'(1);
    end

    assign rel_wide     = {{IDX_W{1'b0}}, cmd.release_core};
    assign rel_in_range = rel_wide < RW'(NUM_CORES);

    // shared compare unit
    assign fit_sum = {1'b0, rd_data} + {1'b0, task_reg};
    assign fit_now = fit_sum <= {1'b0, cfg.core_capacity};

    assign pick_idx  = have_idle_reg ? idle_idx_reg : least_idx_reg;
    assign pick_wide = {{CORE_FLD_W{1'b0}}, pick_idx};
    assign rel_sub   = (rd_data > task_reg) ? (rd_data - task_reg) : '0;

    always_comb
    begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        last_idx_next  = last_idx_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = scan_idx_reg;
        fit_next       = fit_reg;
        have_idle_next = have_idle_reg;
        idle_idx_next  = idle_idx_reg;
        least_next     = least_reg;
        least_idx_next = least_idx_reg;
        task_next      = task_reg;
        rel_next       = rel_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        rd_en          = 1'b0;
        rd_addr        = scan_idx_reg;
        wr_en          = 1'b0;
        wr_addr        = pick_idx;
        wr_data        = have_idle_reg ? task_reg : LOAD_W'(least_reg + task_reg);

        // fold in the load read in the previous cycle
        if (cmp_vld_reg)
        begin
            if (fit_now)
            begin
                fit_next = 1'b1;
            end
            if (!have_idle_reg && rd_data == '0)
            begin
                have_idle_next = 1'b1;
                idle_idx_next  = cmp_idx_reg;
            end
            if (cmp_idx_reg == '0 || rd_data < least_reg)
            begin
                least_next     = rd_data;
                least_idx_next = cmp_idx_reg;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    task_next = cmd.job_load;
                    rel_next  = cmd.release_core;
                    if (cmd.kind == KIND_RELEASE)
                    begin
                        if (rel_in_range)
                        begin
                            state_next = S_REL_RD;
                        end
                        else
                        begin
                            done_next               = 1'b1;
                            result_next.status      = ST_RELEASED;
                            result_next.chosen_core = cmd.release_core;
                        end
                    end
                    else
                    begin
                        state_next     = S_SCAN;
                        scan_idx_next  = '0;
                        last_idx_next  = act_last[IDX_W-1:0];
                        fit_next       = 1'b0;
                        have_idle_next = 1'b0;
                    end
                end
            end
            S_SCAN:
            begin
                rd_en         = 1'b1;
                rd_addr       = scan_idx_reg;
                cmp_vld_next  = 1'b1;
                cmp_idx_next  = scan_idx_reg;
                if (scan_idx_reg == last_idx_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (fit_reg)
                begin
                    wr_en                   = 1'b1;
                    result_next.status      = ST_ASSIGNED;
                    result_next.chosen_core = pick_wide[CORE_FLD_W-1:0];
                end
                else
                begin
                    result_next.status      = ST_NOFIT;
                    result_next.chosen_core = '0;
                end
            end
            S_REL_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = rel_wide_idx(rel_reg);
                state_next = S_REL_WR;
            end
            S_REL_WR:
            begin
                wr_en                   = 1'b1;
                wr_addr                 = rel_wide_idx(rel_reg);
                wr_data                 = rel_sub;
                state_next              = S_IDLE;
                done_next               = 1'b1;
                result_next.status      = ST_RELEASED;
                result_next.chosen_core = rel_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmp_vld_reg   <= 1'b0;
            done_reg      <= 1'b0;
            fit_reg       <= 1'b0;
            have_idle_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_vld_reg   <= cmp_vld_next;
            done_reg      <= done_next;
            fit_reg       <= fit_next;
            have_idle_reg <= have_idle_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg  <= scan_idx_next;
        last_idx_reg  <= last_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        idle_idx_reg  <= idle_idx_next;
        least_reg     <= least_next;
        least_idx_reg <= least_idx_next;
        task_reg      <= task_next;
        rel_reg       <= rel_next;
        result_reg    <= result_next;
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> src/core_load_dispatcher.sv
// ----------------------------------------------------------------------------
// core_load_dispatcher
// least-loaded core dispatch with idle-core preference over per-core loads
// ----------------------------------------------------------------------------
// usage:
//   a command transaction is taken at a clock edge with start high and busy
//   low. kind selects assign (scan for a core, add job_load to it) or
//   release (subtract job_load from release_core, saturating at zero).
//   each command gives exactly one result transaction: done is high for one
//   cycle with result valid, and the receiver cannot hold it off.
//   an assign scans the searched cores (active_cores clamped to 1..NUM_CORES);
//   the load memory is read one core per cycle through a single read port
//   and one shared compare unit. a release reads, then writes back, the
//   core's load; when release_core is beyond the core count no memory is
//   touched. busy is high until the result is registered, so a new command
//   can be taken in the cycle done shows. the user must write configuration
//   (cfg_wr_en, cfg_index, cfg_wdata) only while no command is in flight;
//   the block does not enforce it. reset: all core loads read as zero at once
//   (per-core valid bits); active_cores resets to 16, core_capacity to 1.0.
// ----------------------------------------------------------------------------
module core_load_dispatcher #(
    parameter int NUM_CORES      = 16,
    parameter int LOAD_FRAC_BITS = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  cld_pkg::cmd_t                  cmd,
    output logic                           busy,
    output logic                           done,
    output cld_pkg::result_t               result,
    input  logic                           cfg_wr_en,
    input  logic [cld_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cld_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import cld_pkg::*;

    // core index width, at least one bit
    localparam int IDX_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;

    // capacity reset is 1.0, saturated to the load width
    localparam int CAP_ONE_RAW = (LOAD_FRAC_BITS >= LOAD_W) ? ((1 << LOAD_W) - 1)
                                                            : (1 << LOAD_FRAC_BITS);
    localparam logic [LOAD_W-1:0] CAP_RESET = LOAD_W'(CAP_ONE_RAW);
    localparam logic [ACT_W-1:0]  ACT_RESET = ACT_W'(16);

    cfg_t cfg_reg, cfg_next;

    // memory port wires between sequencer and load ram
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [LOAD_W-1:0] rd_data;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [LOAD_W-1:0] wr_data;

    // configuration registers; user writes only between commands, unchecked
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_ACTIVE_CORES:  cfg_next.active_cores  = cfg_wdata[ACT_W-1:0];
                CFG_CORE_CAPACITY: cfg_next.core_capacity = cfg_wdata[LOAD_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_cores  <= ACT_RESET;
            cfg_reg.core_capacity <= CAP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // scan sequencer with the shared compare/add unit
    cld_sequencer #(
        .NUM_CORES (NUM_CORES),
        .IDX_W     (IDX_W)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .start   (start),
        .cmd     (cmd),
        .busy    (busy),
        .done    (done),
        .result  (result),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // per-core load storage
    cld_load_ram #(
        .NUM_CORES (NUM_CORES),
        .IDX_W     (IDX_W)
    ) u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule
